// ===== hw/rtl/pdh_pkg.sv =====
// ----------------------------------------------------------------------------
// pdh_pkg
// Types and constants shared by the pair distance histogram block.
// ----------------------------------------------------------------------------
package pdh_pkg;

  localparam int POS_W    = 24;
  localparam int REG_W    = 23;
  localparam int COUNT_W  = 32;
  localparam int FRAMES_W = 16;
  localparam int PART_W   = 9;
  localparam int SEL_W    = 6;
  localparam int DIFF_W   = 26;
  localparam int MAG_W    = 24;
  localparam int PROD_W   = 2 * MAG_W;
  localparam int SUM_W    = 50;
  localparam int ROOT_W   = 25;
  localparam int DIVN_W   = 22;

  localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;
  localparam logic [FRAMES_W-1:0] FRAMES_MAX = '1;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [1:0] CFG_BOX_X    = 2'd0;
  localparam logic [1:0] CFG_BOX_Y    = 2'd1;
  localparam logic [1:0] CFG_BOX_Z    = 2'd2;
  localparam logic [1:0] CFG_BIN_SIZE = 2'd3;

  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_LOAD,
    CMD_LOAD_LAST,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [SEL_W-1:0]        bin_select;
  } cmd_t;

  typedef struct packed {
    logic [REG_W-1:0] box_x;
    logic [REG_W-1:0] box_y;
    logic [REG_W-1:0] box_z;
    logic [REG_W-1:0] bin_size;
  } cfg_t;

  typedef struct packed {
    logic                kind;
    logic [COUNT_W-1:0]  bin_count;
    logic [FRAMES_W-1:0] frames;
    logic [PART_W-1:0]   particles;
  } res_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START,
    ST_PAIR_RD,
    ST_DIFF,
    ST_WRAP1,
    ST_WRAP2,
    ST_ABS,
    ST_SQ,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_BIN,
    ST_DIV_WAIT,
    ST_HIST_RD,
    ST_HIST_WR,
    ST_NEXT,
    ST_FRAME_DONE,
    ST_READ_WAIT,
    ST_EMIT
  } state_t;

endpackage

// ===== hw/rtl/pdh_ram.sv =====
// ----------------------------------------------------------------------------
// pdh_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pdh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/pdh_front.sv =====
// ----------------------------------------------------------------------------
// pdh_front
// Input side: accept items, classify requests, queue them for the back end.
// ----------------------------------------------------------------------------
module pdh_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [79:0]          s_tdata,
  input  logic [1:0]           s_tuser,
  input  logic                 s_tlast,
  output logic                 q_valid,
  output pdh_pkg::cmd_t        q_item,
  input  logic                 q_pop
);

  pdh_pkg::cmd_t entry [2];
  pdh_pkg::cmd_t in_cmd;
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic [1:0]    count_next;
  logic          known;
  logic          push;

  always_comb begin
    in_cmd.kind       = pdh_pkg::CMD_CLEAR;
    in_cmd.pos_x      = s_tdata[23:0];
    in_cmd.pos_y      = s_tdata[47:24];
    in_cmd.pos_z      = s_tdata[71:48];
    in_cmd.bin_select = s_tdata[77:72];
    known             = 1'b1;
    case (s_tuser)
      pdh_pkg::REQ_CLEAR: in_cmd.kind = pdh_pkg::CMD_CLEAR;
      pdh_pkg::REQ_LOAD:  in_cmd.kind = s_tlast ? pdh_pkg::CMD_LOAD_LAST : pdh_pkg::CMD_LOAD;
      pdh_pkg::REQ_READ:  in_cmd.kind = pdh_pkg::CMD_READ;
      default:            known = 1'b0;
    endcase
  end

  assign s_tready   = (count != 2'd2);
  assign push       = s_tvalid && s_tready && known;
  assign q_valid    = (count != 2'd0);
  assign q_item     = entry[rd_ptr];
  assign count_next = count + {1'b0, push} - {1'b0, q_pop};

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count_next;
    end
  end

endmodule

// ===== hw/rtl/pdh_isqrt.sv =====
// ----------------------------------------------------------------------------
// pdh_isqrt
// Integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pdh_isqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [pdh_pkg::SUM_W-1:0]    value,
  output logic                         busy,
  output logic [pdh_pkg::ROOT_W-1:0]   root
);

  logic [pdh_pkg::SUM_W-1:0]    val;
  logic [pdh_pkg::ROOT_W:0]     rem;
  logic [pdh_pkg::ROOT_W+1:0]   rem_sh;
  logic [pdh_pkg::ROOT_W+1:0]   trial;
  logic [pdh_pkg::ROOT_W+1:0]   rem_diff;
  logic                         ge;
  logic [4:0]                   cnt;

  always_comb begin
    rem_sh   = {rem[pdh_pkg::ROOT_W-1:0], val[pdh_pkg::SUM_W-1 -: 2]};
    trial    = {root, 2'b01};
    ge       = (rem_sh >= trial);
    rem_diff = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val  <= value;
      rem  <= '0;
      root <= '0;
      cnt  <= 5'(pdh_pkg::ROOT_W - 1);
    end else if (busy) begin
      val  <= {val[pdh_pkg::SUM_W-3:0], 2'b00};
      rem  <= ge ? rem_diff[pdh_pkg::ROOT_W:0] : rem_sh[pdh_pkg::ROOT_W:0];
      root <= {root[pdh_pkg::ROOT_W-2:0], ge};
      cnt  <= cnt - 5'd1;
    end
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == 5'd0) begin
      busy <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/pdh_div.sv =====
// ----------------------------------------------------------------------------
// pdh_div
// Restoring divider for the bin index, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pdh_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pdh_pkg::DIVN_W-1:0]  dividend,
  input  logic [pdh_pkg::REG_W-1:0]   divisor,
  output logic                        busy,
  output logic [pdh_pkg::DIVN_W-1:0]  quotient
);

  logic [pdh_pkg::REG_W-1:0] rem;
  logic [pdh_pkg::REG_W:0]   rem_sh;
  logic [pdh_pkg::REG_W:0]   rem_diff;
  logic                      ge;
  logic [4:0]                cnt;

  always_comb begin
    rem_sh   = {rem, quotient[pdh_pkg::DIVN_W-1]};
    ge       = (rem_sh >= {1'b0, divisor});
    rem_diff = rem_sh - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      cnt      <= 5'(pdh_pkg::DIVN_W - 1);
    end else if (busy) begin
      quotient <= {quotient[pdh_pkg::DIVN_W-2:0], ge};
      rem      <= ge ? rem_diff[pdh_pkg::REG_W-1:0] : rem_sh[pdh_pkg::REG_W-1:0];
      cnt      <= cnt - 5'd1;
    end
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == 5'd0) begin
      busy <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/pdh_back.sv =====
// ----------------------------------------------------------------------------
// pdh_back
// Back end: particle store, pair sequencer, histogram and result register.
// ----------------------------------------------------------------------------
module pdh_back #(
  parameter int MAX_PARTICLES = 256,
  parameter int NUM_BINS      = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  pdh_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  pdh_pkg::cmd_t  q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output pdh_pkg::res_t  out_res
);

  localparam int IDX_W  = MAX_PARTICLES > 1 ? $clog2(MAX_PARTICLES) : 1;
  localparam int FILL_W = $clog2(MAX_PARTICLES + 1);
  localparam int BIN_AW = NUM_BINS > 1 ? $clog2(NUM_BINS) : 1;
  localparam int PT_W   = 3 * pdh_pkg::POS_W;

  pdh_pkg::state_t state;
  pdh_pkg::state_t state_next;

  logic [FILL_W-1:0]              fill;
  logic [IDX_W-1:0]               idx_i;
  logic [IDX_W-1:0]               idx_j;
  logic [pdh_pkg::FRAMES_W-1:0]   frame_count;
  logic [NUM_BINS-1:0]            hvalid;
  logic [pdh_pkg::SEL_W-1:0]      rd_sel;
  logic [pdh_pkg::DIVN_W-1:0]     bin_q;
  logic [1:0]                     sq_cnt;
  logic [pdh_pkg::PROD_W-1:0]     prod;
  logic [pdh_pkg::SUM_W-1:0]      sum;
  logic signed [pdh_pkg::DIFF_W-1:0] d [3];
  logic [pdh_pkg::MAG_W-1:0]      amag [3];
  pdh_pkg::res_t                  res;

  logic signed [pdh_pkg::DIFF_W:0]   two_d [3];
  logic signed [pdh_pkg::DIFF_W:0]   len_w [3];
  logic signed [pdh_pkg::DIFF_W-1:0] w1 [3];
  logic signed [pdh_pkg::DIFF_W-1:0] w2 [3];
  logic signed [pdh_pkg::DIFF_W-1:0] neg_d [3];
  logic [pdh_pkg::REG_W-1:0]         blen [3];
  logic [pdh_pkg::POS_W-1:0]         pi_c [3];
  logic [pdh_pkg::POS_W-1:0]         pj_c [3];
  logic [pdh_pkg::MAG_W-1:0]         sq_op;

  logic                    store_we;
  logic                    pair_re;
  logic                    hist_re;
  logic                    hist_we;
  logic                    root_start;
  logic                    div_start;
  logic                    out_load;
  logic [BIN_AW-1:0]       hist_raddr;
  logic [BIN_AW-1:0]       bin_addr;
  logic [PT_W-1:0]         pt_i;
  logic [PT_W-1:0]         pt_j;
  logic [pdh_pkg::COUNT_W-1:0] hist_q;
  logic [pdh_pkg::COUNT_W-1:0] hist_old;
  logic [pdh_pkg::COUNT_W-1:0] hist_new;
  logic                    root_busy;
  logic [pdh_pkg::ROOT_W-1:0] root;
  logic                    div_busy;
  logic [pdh_pkg::DIVN_W-1:0] quo;
  logic [pdh_pkg::REG_W-1:0]  width;
  logic                    in_cut;
  logic                    more_j;
  logic                    more_i;

  assign blen[0] = cfg.box_x;
  assign blen[1] = cfg.box_y;
  assign blen[2] = cfg.box_z;
  assign width   = (cfg.bin_size == '0) ? pdh_pkg::REG_W'(1) : cfg.bin_size;
  assign bin_addr = BIN_AW'(bin_q);

  pdh_ram #(.WIDTH(PT_W), .DEPTH(MAX_PARTICLES)) u_store_i (
    .clk   (clk),
    .we    (store_we),
    .waddr (IDX_W'(fill)),
    .wdata ({q_item.pos_z, q_item.pos_y, q_item.pos_x}),
    .re    (pair_re),
    .raddr (idx_i),
    .rdata (pt_i)
  );

  pdh_ram #(.WIDTH(PT_W), .DEPTH(MAX_PARTICLES)) u_store_j (
    .clk   (clk),
    .we    (store_we),
    .waddr (IDX_W'(fill)),
    .wdata ({q_item.pos_z, q_item.pos_y, q_item.pos_x}),
    .re    (pair_re),
    .raddr (idx_j),
    .rdata (pt_j)
  );

  pdh_ram #(.WIDTH(pdh_pkg::COUNT_W), .DEPTH(NUM_BINS)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (bin_addr),
    .wdata (hist_new),
    .re    (hist_re),
    .raddr (hist_raddr),
    .rdata (hist_q)
  );

  pdh_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .value (sum),
    .busy  (root_busy),
    .root  (root)
  );

  pdh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (root[pdh_pkg::DIVN_W-1:0] - pdh_pkg::DIVN_W'(1)),
    .divisor  (width),
    .busy     (div_busy),
    .quotient (quo)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pi_c[k]  = pt_i[k*pdh_pkg::POS_W +: pdh_pkg::POS_W];
      pj_c[k]  = pt_j[k*pdh_pkg::POS_W +: pdh_pkg::POS_W];
      two_d[k] = {d[k], 1'b0};
      len_w[k] = $signed({4'b0000, blen[k]});
      w1[k]    = (two_d[k] > len_w[k]) ? d[k] - $signed({3'b000, blen[k]}) : d[k];
      w2[k]    = (two_d[k] + len_w[k] < 0) ? d[k] + $signed({3'b000, blen[k]}) : d[k];
      neg_d[k] = -d[k];
    end
  end

  always_comb begin
    case (sq_cnt)
      2'd0:    sq_op = amag[0];
      2'd1:    sq_op = amag[1];
      default: sq_op = amag[2];
    endcase
  end

  assign in_cut   = ({root, 1'b0} < {3'b000, cfg.box_z});
  assign more_j   = (FILL_W'(idx_j) + FILL_W'(1) < fill);
  assign more_i   = (FILL_W'(idx_i) + FILL_W'(2) < fill);
  assign hist_old = hvalid[bin_addr] ? hist_q : '0;
  assign hist_new = (hist_old > pdh_pkg::COUNT_MAX - pdh_pkg::COUNT_W'(2)) ?
                    pdh_pkg::COUNT_MAX : hist_old + pdh_pkg::COUNT_W'(2);

  always_comb begin
    state_next = state;
    case (state)
      pdh_pkg::ST_IDLE: begin
        if (q_valid) begin
          case (q_item.kind)
            pdh_pkg::CMD_LOAD_LAST: state_next = pdh_pkg::ST_START;
            pdh_pkg::CMD_READ:      state_next = pdh_pkg::ST_READ_WAIT;
            default:                state_next = pdh_pkg::ST_IDLE;
          endcase
        end
      end
      pdh_pkg::ST_START:
        state_next = (fill >= FILL_W'(2)) ? pdh_pkg::ST_PAIR_RD : pdh_pkg::ST_FRAME_DONE;
      pdh_pkg::ST_PAIR_RD:   state_next = pdh_pkg::ST_DIFF;
      pdh_pkg::ST_DIFF:      state_next = pdh_pkg::ST_WRAP1;
      pdh_pkg::ST_WRAP1:     state_next = pdh_pkg::ST_WRAP2;
      pdh_pkg::ST_WRAP2:     state_next = pdh_pkg::ST_ABS;
      pdh_pkg::ST_ABS:       state_next = pdh_pkg::ST_SQ;
      pdh_pkg::ST_SQ:
        state_next = (sq_cnt == 2'd3) ? pdh_pkg::ST_ROOT_GO : pdh_pkg::ST_SQ;
      pdh_pkg::ST_ROOT_GO:   state_next = pdh_pkg::ST_ROOT_WAIT;
      pdh_pkg::ST_ROOT_WAIT:
        state_next = root_busy ? pdh_pkg::ST_ROOT_WAIT : pdh_pkg::ST_BIN;
      pdh_pkg::ST_BIN: begin
        if (!in_cut) begin
          state_next = pdh_pkg::ST_NEXT;
        end else if (root == '0) begin
          state_next = pdh_pkg::ST_HIST_RD;
        end else begin
          state_next = pdh_pkg::ST_DIV_WAIT;
        end
      end
      pdh_pkg::ST_DIV_WAIT:
        state_next = div_busy ? pdh_pkg::ST_DIV_WAIT : pdh_pkg::ST_HIST_RD;
      pdh_pkg::ST_HIST_RD:
        state_next = (bin_q < NUM_BINS) ? pdh_pkg::ST_HIST_WR : pdh_pkg::ST_NEXT;
      pdh_pkg::ST_HIST_WR:   state_next = pdh_pkg::ST_NEXT;
      pdh_pkg::ST_NEXT:
        state_next = (more_j || more_i) ? pdh_pkg::ST_PAIR_RD : pdh_pkg::ST_FRAME_DONE;
      pdh_pkg::ST_FRAME_DONE: state_next = pdh_pkg::ST_EMIT;
      pdh_pkg::ST_READ_WAIT:  state_next = pdh_pkg::ST_EMIT;
      pdh_pkg::ST_EMIT:
        state_next = (!out_valid || out_ready) ? pdh_pkg::ST_IDLE : pdh_pkg::ST_EMIT;
      default:                state_next = pdh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    store_we   = 1'b0;
    pair_re    = 1'b0;
    hist_re    = 1'b0;
    hist_we    = 1'b0;
    root_start = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    hist_raddr = bin_addr;
    case (state)
      pdh_pkg::ST_IDLE: begin
        q_pop      = q_valid;
        store_we   = q_valid && (fill < MAX_PARTICLES) &&
                     (q_item.kind == pdh_pkg::CMD_LOAD || q_item.kind == pdh_pkg::CMD_LOAD_LAST);
        hist_re    = q_valid && (q_item.kind == pdh_pkg::CMD_READ);
        hist_raddr = BIN_AW'(q_item.bin_select);
      end
      pdh_pkg::ST_PAIR_RD: pair_re    = 1'b1;
      pdh_pkg::ST_ROOT_GO: root_start = 1'b1;
      pdh_pkg::ST_BIN:     div_start  = in_cut && (root != '0);
      pdh_pkg::ST_HIST_RD: hist_re    = (bin_q < NUM_BINS);
      pdh_pkg::ST_HIST_WR: hist_we    = 1'b1;
      pdh_pkg::ST_EMIT:    out_load   = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      pdh_pkg::ST_IDLE: rd_sel <= q_item.bin_select;
      pdh_pkg::ST_START: begin
        idx_i <= '0;
        idx_j <= IDX_W'(1);
      end
      pdh_pkg::ST_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          d[k] <= $signed({{2{pi_c[k][pdh_pkg::POS_W-1]}}, pi_c[k]}) -
                  $signed({{2{pj_c[k][pdh_pkg::POS_W-1]}}, pj_c[k]});
        end
      end
      pdh_pkg::ST_WRAP1: d <= w1;
      pdh_pkg::ST_WRAP2: begin
        d      <= w2;
        sq_cnt <= 2'd0;
      end
      pdh_pkg::ST_ABS: begin
        for (int k = 0; k < 3; k++) begin
          amag[k] <= d[k][pdh_pkg::DIFF_W-1] ? neg_d[k][pdh_pkg::MAG_W-1:0]
                                             : d[k][pdh_pkg::MAG_W-1:0];
        end
      end
      pdh_pkg::ST_SQ: begin
        prod   <= sq_op * sq_op;
        sum    <= (sq_cnt == 2'd0) ? '0 : sum + pdh_pkg::SUM_W'(prod);
        sq_cnt <= sq_cnt + 2'd1;
      end
      pdh_pkg::ST_BIN:      bin_q <= '0;
      pdh_pkg::ST_DIV_WAIT: bin_q <= quo;
      pdh_pkg::ST_NEXT: begin
        if (more_j) begin
          idx_j <= idx_j + IDX_W'(1);
        end else begin
          idx_i <= idx_i + IDX_W'(1);
          idx_j <= idx_i + IDX_W'(2);
        end
      end
      pdh_pkg::ST_FRAME_DONE: begin
        res.kind      <= pdh_pkg::KIND_ACK;
        res.bin_count <= '0;
        res.frames    <= (frame_count != pdh_pkg::FRAMES_MAX) ?
                         frame_count + pdh_pkg::FRAMES_W'(1) : frame_count;
        res.particles <= pdh_pkg::PART_W'(fill);
      end
      pdh_pkg::ST_READ_WAIT: begin
        res.kind      <= pdh_pkg::KIND_READ;
        res.bin_count <= (rd_sel < NUM_BINS && hvalid[BIN_AW'(rd_sel)]) ? hist_q : '0;
        res.frames    <= frame_count;
        res.particles <= pdh_pkg::PART_W'(fill);
      end
      default: ;
    endcase
    if (out_load) begin
      out_res <= res;
    end

    if (rst) begin
      state       <= pdh_pkg::ST_IDLE;
      fill        <= '0;
      frame_count <= '0;
      hvalid      <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (store_we) begin
        fill <= fill + FILL_W'(1);
      end
      if (state == pdh_pkg::ST_IDLE && q_valid && q_item.kind == pdh_pkg::CMD_CLEAR) begin
        frame_count <= '0;
        hvalid      <= '0;
      end
      if (hist_we) begin
        hvalid[bin_addr] <= 1'b1;
      end
      if (state == pdh_pkg::ST_FRAME_DONE) begin
        fill <= '0;
        if (frame_count != pdh_pkg::FRAMES_MAX) begin
          frame_count <= frame_count + pdh_pkg::FRAMES_W'(1);
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    state == pdh_pkg::ST_PAIR_RD |-> idx_j > idx_i && FILL_W'(idx_j) < fill)
    else $error("pair indices out of order or past the fill");

  a_hist_range: assert property (@(posedge clk) disable iff (rst)
    hist_we |-> bin_q < NUM_BINS && $past(state) == pdh_pkg::ST_HIST_RD)
    else $error("histogram write outside the bin range");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    state == pdh_pkg::ST_FRAME_DONE |=> fill == '0 && frame_count != '0)
    else $error("frame end left fill or frame count wrong");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (root_busy || div_busy) |-> !q_pop && !out_load)
    else $error("queue popped while a pair is in flight");

endmodule

// ===== hw/rtl/pair_distance_histogram.sv =====
// ----------------------------------------------------------------------------
// pair_distance_histogram
// Histogram of minimum-image pair distances for the radial distribution
// function, with frame counting and bin read-back.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  clear, load particle or read bin
//  m_*      out  m_tvalid/m_tready  frame acknowledgement or bin data
//  cfg_*    in   cfg_we             box lengths and bin width
//
//  Unused codes are dropped at the input; clear and load are taken while idle;
//  a read passes through READ_WAIT to EMIT. Each pair of a frame runs the
//  25-step square root unit and, at a nonzero distance inside the cutoff, the
//  22-step divider. Histogram entries carry valid bits, so no reset sweep runs.
//  A two-item queue decouples input from the sequencer; the result register
//  holds until taken while the next items queue up.
// ----------------------------------------------------------------------------
module pair_distance_histogram #(
  parameter int MAX_PARTICLES = 256,
  parameter int NUM_BINS      = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // pos_x[23:0], pos_y[47:24], pos_z[71:48], bin_select[77:72]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // bin_count[31:0], frames_sampled[47:32],
                                 // particles_in_frame[56:48]
  output logic [0:0]  m_tuser,   // result_kind[0]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [22:0] cfg_wdata
);

  pdh_pkg::cfg_t cfg;
  logic          q_valid;
  pdh_pkg::cmd_t q_item;
  logic          q_pop;
  pdh_pkg::res_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.box_x    <= 23'd25600;
      cfg.box_y    <= 23'd25600;
      cfg.box_z    <= 23'd25600;
      cfg.bin_size <= 23'd256;
    end else if (cfg_we) begin
      case (cfg_addr)
        pdh_pkg::CFG_BOX_X:    cfg.box_x    <= cfg_wdata;
        pdh_pkg::CFG_BOX_Y:    cfg.box_y    <= cfg_wdata;
        pdh_pkg::CFG_BOX_Z:    cfg.box_z    <= cfg_wdata;
        pdh_pkg::CFG_BIN_SIZE: cfg.bin_size <= cfg_wdata;
        default: ;
      endcase
    end
  end

  pdh_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  pdh_back #(.MAX_PARTICLES(MAX_PARTICLES), .NUM_BINS(NUM_BINS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {7'd0, res.particles, res.frames, res.bin_count};
  assign m_tuser = res.kind;

endmodule

// ===== dv/tb_pair_distance_histogram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pair_distance_histogram
// Self-checking bench for the pair distance histogram. A table of directed
// requests and a full-store frame come first. Random clear, load, read and unused
// code traffic follows under several box and bin settings and idling mixes, with
// one long output hold. Every result is compared with a local model of the
// histogram, the frame count and the particle store, or with a fixed table result.
// ----------------------------------------------------------------------------
module tb_pair_distance_histogram;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int STORE_DEPTH = 256;
  localparam int HIST_BINS   = 64;
  localparam int STALL_LIMIT = 8000000;

  typedef struct {
    logic [1:0]                       req;
    logic signed [pdh_pkg::POS_W-1:0] x;
    logic signed [pdh_pkg::POS_W-1:0] y;
    logic signed [pdh_pkg::POS_W-1:0] z;
    logic                             last;
    logic [pdh_pkg::SEL_W-1:0]        sel;
    bit                               fixed;
    pdh_pkg::res_t                    res;
  } req_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [22:0] cfg_wdata = '0;

  bit            cur_fixed = 1'b0;
  pdh_pkg::res_t cur_res = '0;

  pair_distance_histogram u_dut (.*);

  always #1 clk = ~clk;

  longint          store_x [STORE_DEPTH];
  longint          store_y [STORE_DEPTH];
  longint          store_z [STORE_DEPTH];
  int              store_fill = 0;
  bit [31:0]       hist [HIST_BINS];
  int              frames = 0;
  longint          box_x = 25600, box_y = 25600, box_z = 25600, bin_w = 256;
  pdh_pkg::res_t   pending_res [$];
  int              errors = 0;
  int              idle_pct = 0, stall_pct = 0;
  int              hold_req = 0, hold_left = 0;
  int              quiet_cycles = 0;

  function automatic longint wrap_min_image(longint d, longint len);
    if (2 * d > len) d -= len;
    if (2 * d < -len) d += len;
    return d < 0 ? -d : d;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  task automatic accumulate_frame();
    longint ax, ay, az, w;
    longint unsigned r, b;
    w = bin_w ? bin_w : 1;
    for (int i = 0; i + 1 < store_fill; i++) begin
      for (int j = i + 1; j < store_fill; j++) begin
        ax = wrap_min_image(store_x[i] - store_x[j], box_x);
        ay = wrap_min_image(store_y[i] - store_y[j], box_y);
        az = wrap_min_image(store_z[i] - store_z[j], box_z);
        r = root_floor(ax * ax + ay * ay + az * az);
        if (2 * r >= box_z) continue;
        b = (r + w - 1) / w;
        if (b > 0) b -= 1;
        if (b >= HIST_BINS) continue;
        hist[b] = (hist[b] > 32'hFFFF_FFFD) ? pdh_pkg::COUNT_MAX : hist[b] + 32'd2;
      end
    end
    if (frames < pdh_pkg::FRAMES_MAX) frames++;
  endtask

  task automatic predict_item(logic [1:0] req, logic [79:0] d, logic last);
    pdh_pkg::res_t r;
    r = '0;
    case (req)
      pdh_pkg::REQ_CLEAR: begin
        foreach (hist[k]) hist[k] = 0;
        frames = 0;
      end
      pdh_pkg::REQ_LOAD: begin
        if (store_fill < STORE_DEPTH) begin
          store_x[store_fill] = longint'(signed'(d[23:0]));
          store_y[store_fill] = longint'(signed'(d[47:24]));
          store_z[store_fill] = longint'(signed'(d[71:48]));
          store_fill++;
        end
        if (last) begin
          accumulate_frame();
          r.kind = pdh_pkg::KIND_ACK;
          r.frames = pdh_pkg::FRAMES_W'(frames);
          r.particles = pdh_pkg::PART_W'(store_fill);
          store_fill = 0;
          pending_res.push_back(r);
        end
      end
      pdh_pkg::REQ_READ: begin
        r.kind = pdh_pkg::KIND_READ;
        r.bin_count = hist[d[77:72]];
        r.frames = pdh_pkg::FRAMES_W'(frames);
        r.particles = pdh_pkg::PART_W'(store_fill);
        pending_res.push_back(r);
      end
      default: ;
    endcase
  endtask

  // prediction at input acceptance, checking at output acceptance
  always @(posedge clk) begin
    pdh_pkg::res_t got, want;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (s_tvalid && s_tready) begin
        predict_item(s_tuser, s_tdata, s_tlast);
        if (cur_fixed && pending_res.size() != 0) begin
          pending_res.pop_back();
          pending_res.push_back(cur_res);
        end
      end
      if (m_tvalid && m_tready) begin
        got.kind = m_tuser[0];
        got.bin_count = m_tdata[31:0];
        got.frames = m_tdata[47:32];
        got.particles = m_tdata[56:48];
        if (pending_res.size() == 0) begin
          errors++;
          $display("%0t: unexpected result kind=%0d count=%0d frames=%0d parts=%0d",
                   $time, got.kind, got.bin_count, got.frames, got.particles);
        end else begin
          want = pending_res.pop_front();
          if (got.kind != want.kind || got.bin_count != want.bin_count ||
              got.frames != want.frames || got.particles != want.particles) begin
            errors++;
            $display("%0t: mismatch expected kind=%0d count=%0d frames=%0d parts=%0d",
                     $time, want.kind, want.bin_count, want.frames, want.particles);
            $display("%0t:          actual   kind=%0d count=%0d frames=%0d parts=%0d",
                     $time, got.kind, got.bin_count, got.frames, got.particles);
          end
        end
      end
      if (quiet_cycles > STALL_LIMIT) begin
        $display("tb_pair_distance_histogram failed");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req != 0) begin
      hold_left = 400;
      hold_req = 0;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= $urandom_range(99) >= stall_pct;
    end
  end

  task automatic send(req_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid  <= 1'b1;
    s_tuser   <= it.req;
    s_tlast   <= it.last;
    s_tdata   <= {2'b00, it.sel, it.z, it.y, it.x};
    cur_fixed <= it.fixed;
    cur_res   <= it.res;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_res.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic program_box(int bx, int by, int bz, int bw);
    int vals [4];
    vals = '{bx, by, bz, bw};
    for (int k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= k[1:0];
      cfg_wdata <= vals[k][22:0];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    box_x = bx; box_y = by; box_z = bz; bin_w = bw;
  endtask

  function automatic req_item_t mk(logic [1:0] req, int x, int y, int z, bit last,
                                   int sel, bit fixed = 0, bit kind = 0,
                                   int frm = 0, int parts = 0);
    req_item_t it;
    it.req = req;
    it.x = pdh_pkg::POS_W'(x);
    it.y = pdh_pkg::POS_W'(y);
    it.z = pdh_pkg::POS_W'(z);
    it.last = last;
    it.sel = pdh_pkg::SEL_W'(sel);
    it.fixed = fixed;
    it.res = '{kind: kind, bin_count: '0, frames: pdh_pkg::FRAMES_W'(frm),
               particles: pdh_pkg::PART_W'(parts)};
    return it;
  endfunction

  function automatic logic signed [pdh_pkg::POS_W-1:0] rand_pos(int span);
    if ($urandom_range(4) == 0) return pdh_pkg::POS_W'($urandom);
    return pdh_pkg::POS_W'($urandom_range(2 * span) - span);
  endfunction

  req_item_t directed [];
  req_item_t it;
  int        gen_fill;
  int        span;
  int        r;

  initial begin
    directed = '{
      mk(pdh_pkg::REQ_READ, 0, 0, 0, 0, 0, 1, pdh_pkg::KIND_READ, 0, 0),
      mk(pdh_pkg::REQ_READ, 0, 0, 0, 1, 63, 1, pdh_pkg::KIND_READ, 0, 0),
      mk(REQ_UNUSED, -1, -1, -1, 1, 63),
      mk(pdh_pkg::REQ_LOAD, 8388607, -8388608, 0, 1, 63, 1, pdh_pkg::KIND_ACK, 1, 1),
      mk(pdh_pkg::REQ_LOAD, -8388608, 8388607, -8388608, 0, 0),
      mk(pdh_pkg::REQ_LOAD, 8388607, -8388608, 8388607, 1, 0),
      mk(pdh_pkg::REQ_LOAD, 0, 0, 0, 0, 0),
      mk(pdh_pkg::REQ_LOAD, 0, 0, 0, 1, 0),
      mk(pdh_pkg::REQ_READ, 0, 0, 0, 0, 0),
      mk(pdh_pkg::REQ_LOAD, 100, 200, 300, 0, 0),
      mk(pdh_pkg::REQ_LOAD, 12900, 200, 300, 0, 0),
      mk(pdh_pkg::REQ_LOAD, 100, -12700, 300, 0, 0),
      mk(pdh_pkg::REQ_LOAD, 356, 200, 300, 1, 0),
      mk(pdh_pkg::REQ_READ, 0, 0, 0, 0, 0),
      mk(pdh_pkg::REQ_READ, 0, 0, 0, 0, 1),
      mk(pdh_pkg::REQ_READ, 0, 0, 0, 0, 49),
      mk(pdh_pkg::REQ_LOAD, 5, 5, 5, 0, 0),
      mk(pdh_pkg::REQ_READ, 0, 0, 0, 0, 2),
      mk(pdh_pkg::REQ_CLEAR, 0, 0, 0, 0, 0),
      mk(pdh_pkg::REQ_READ, 0, 0, 0, 0, 0),
      mk(pdh_pkg::REQ_LOAD, 700, 800, 900, 1, 0),
      mk(pdh_pkg::REQ_READ, 0, 0, 0, 0, 3)
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[k]) send(directed[k]);

    // overfill the store: the last item is dropped but still closes the frame
    for (int k = 0; k <= STORE_DEPTH; k++)
      send(mk(pdh_pkg::REQ_LOAD, rand_pos(3000), rand_pos(3000), rand_pos(3000),
              k == STORE_DEPTH, $urandom_range(63)));
    send(mk(pdh_pkg::REQ_READ, 0, 0, 0, 0, 5));
    drain();

    gen_fill = 0;
    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0: begin program_box(25600, 25600, 25600, 256); span = 12800; end
        1: begin program_box(1, 1, 1, 1); span = 4; end
        2: begin program_box(8388607, 8388607, 8388607, 8388607); span = 8388607; end
        3: begin program_box(2560, 3000, 2000, 0); span = 1800; end
        4: begin
          program_box($urandom_range(30000, 1000), $urandom_range(30000, 1000),
                      $urandom_range(30000, 1000), $urandom_range(600, 1));
          span = 16000;
        end
        default: begin program_box(4096, 4096, 4096, 20); span = 2400; end
      endcase
      case (seg % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 65; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      for (int n = 0; n < 190; n++) begin
        r = $urandom_range(99);
        it = mk(pdh_pkg::REQ_LOAD, rand_pos(span), rand_pos(span), rand_pos(span),
                $urandom_range(1), $urandom_range(63));
        if (r < 7) begin
          it.req = pdh_pkg::REQ_CLEAR;
        end else if (r < 25) begin
          it.req = pdh_pkg::REQ_READ;
        end else if (r < 28) begin
          it.req = REQ_UNUSED;
        end else begin
          it.last = (gen_fill >= 7) || ($urandom_range(3) == 0);
          gen_fill = it.last ? 0 : gen_fill + 1;
        end
        send(it);
      end
      drain();
    end

    // hold the output long enough for the input to back up
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1;
    for (int n = 0; n < 40; n++)
      send(mk(n % 5 == 4 ? pdh_pkg::REQ_LOAD : pdh_pkg::REQ_READ, $urandom_range(500), 0, 0,
              1, $urandom_range(63)));
    drain();
    repeat (50) @(posedge clk);

    if (errors == 0 && pending_res.size() == 0) begin
      $display("tb_pair_distance_histogram passed");
    end else begin
      $display("tb_pair_distance_histogram failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/pdh_pkg.sv
hw/rtl/pdh_ram.sv
hw/rtl/pdh_front.sv
hw/rtl/pdh_isqrt.sv
hw/rtl/pdh_div.sv
hw/rtl/pdh_back.sv
hw/rtl/pair_distance_histogram.sv
dv/tb_pair_distance_histogram.sv
